[rtl/cursor_insert_delete_buffer_macros.svh]
// Assertion macros shared by the checker of the cursor insert/delete buffer.
`ifndef CURSOR_INSERT_DELETE_BUFFER_MACROS_SVH
`define CURSOR_INSERT_DELETE_BUFFER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CIDB_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cidb assertion failed");

// Next-cycle implication, disabled during reset.
`define CIDB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cidb assertion failed");

`endif

[rtl/cidb_pkg.sv]
// Shared types and constants of the cursor insert/delete buffer.
`timescale 1ns / 1ps

package cidb_pkg;

    localparam int CODE_W     = 32;
    localparam int POS_W      = 12;
    localparam int LEN_OUT_W  = 13;
    localparam int CHANGE_W   = 14;
    localparam int FREE_LIMIT = 10;
    localparam int CHANGE_MAX = 8191;
    localparam int CHANGE_MIN = -8192;

    typedef enum logic [1:0] {
        K_INSERT = 2'd0,
        K_DELETE = 2'd1,
        K_READ   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef struct packed {
        logic en;
        logic we;
    } ram_req_t;

    typedef struct packed {
        logic    valid;
        status_t status;
        logic    edited;
    } seq_res_t;

endpackage

[rtl/cidb_ram.sv]
// Single-port text store with registered read data.
`timescale 1ns / 1ps

module cidb_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                          clk,
    input  cidb_pkg::ram_req_t            req,
    input  logic [AW-1:0]                 addr,
    input  logic [cidb_pkg::CODE_W-1:0]   wdata,
    output logic [cidb_pkg::CODE_W-1:0]   rdata
);

    logic [cidb_pkg::CODE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            if (req.we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

[rtl/cidb_seq.sv]
// Sequencer: checks an operation and walks the shift one entry move at a time.
`timescale 1ns / 1ps

module cidb_seq #(
    parameter int DEPTH = 4096,
    parameter int AW    = $clog2(DEPTH),
    parameter int LW    = $clog2(DEPTH + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          idle,
    input  logic [1:0]                    kind,
    input  logic [cidb_pkg::POS_W-1:0]    position,
    input  logic [cidb_pkg::CODE_W-1:0]   char_code,
    output cidb_pkg::seq_res_t            res,
    input  logic                          res_ready,
    output logic [LW-1:0]                 len,
    output logic [cidb_pkg::CODE_W-1:0]   rdata,
    output cidb_pkg::ram_req_t            ram_req,
    output logic [AW-1:0]                 ram_addr,
    output logic [cidb_pkg::CODE_W-1:0]   ram_wdata,
    input  logic [cidb_pkg::CODE_W-1:0]   ram_rdata
);

    localparam int CW = (LW > cidb_pkg::POS_W) ? LW : cidb_pkg::POS_W;
    localparam logic [LW-1:0] FULL_LEN = LW'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_CHK,
        S_WR,
        S_RDW,
        S_DONE
    } state_t;

    state_t                        state_reg, state_next;
    logic [1:0]                    kind_reg, kind_next;
    logic [cidb_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic [cidb_pkg::CODE_W-1:0]   code_reg, code_next;
    logic [LW-1:0]                 idx_reg, idx_next;
    logic [LW-1:0]                 len_reg, len_next;
    logic                          edited_reg, edited_next;
    cidb_pkg::status_t             status_reg, status_next;
    logic [cidb_pkg::CODE_W-1:0]   rdata_reg, rdata_next;

    logic [LW-1:0] src;
    logic [CW-1:0] pos_ext;
    logic [CW-1:0] len_ext;
    logic          down;
    logic          go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            len_reg    <= '0;
            edited_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            len_reg    <= len_next;
            edited_reg <= edited_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        pos_reg    <= pos_next;
        code_reg   <= code_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        rdata_reg  <= rdata_next;
    end

    // One shared step unit: the source entry sits one place below (insert) or above (delete).
    assign down    = (kind_reg == cidb_pkg::K_INSERT);
    assign src     = down ? (idx_reg - LW'(1)) : (idx_reg + LW'(1));
    assign pos_ext = CW'(pos_reg);
    assign len_ext = CW'(len_reg);
    assign go      = down ? (CW'(idx_reg) > pos_ext) : (CW'(src) < len_ext);

    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        pos_next    = pos_reg;
        code_next   = code_reg;
        idx_next    = idx_reg;
        len_next    = len_reg;
        edited_next = edited_reg;
        status_next = status_reg;
        rdata_next  = rdata_reg;
        ram_req     = '0;
        ram_addr    = idx_reg[AW-1:0];
        ram_wdata   = ram_rdata;
        res         = '0;
        res.status  = status_reg;
        res.edited  = edited_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next  = kind;
                    pos_next   = position;
                    code_next  = char_code;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                status_next = cidb_pkg::ST_DONE;
                rdata_next  = '0;
                case (cidb_pkg::kind_t'(kind_reg))
                    cidb_pkg::K_INSERT:
                    begin
                        edited_next = 1'b1;
                        if (len_reg == FULL_LEN)
                        begin
                            status_next = cidb_pkg::ST_FULL;
                            state_next  = S_DONE;
                        end
                        else if (pos_ext > len_ext)
                        begin
                            status_next = cidb_pkg::ST_RANGE;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            idx_next   = len_reg;
                            state_next = S_CHK;
                        end
                    end
                    cidb_pkg::K_DELETE:
                    begin
                        edited_next = 1'b1;
                        if (len_reg == '0)
                        begin
                            status_next = cidb_pkg::ST_EMPTY;
                            state_next  = S_DONE;
                        end
                        else if (pos_ext >= len_ext)
                        begin
                            status_next = cidb_pkg::ST_RANGE;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            idx_next   = LW'(pos_reg);
                            state_next = S_CHK;
                        end
                    end
                    cidb_pkg::K_READ:
                    begin
                        if (pos_ext >= len_ext)
                        begin
                            status_next = cidb_pkg::ST_RANGE;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            ram_req.en = 1'b1;
                            ram_addr   = AW'(pos_reg);
                            state_next = S_RDW;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_CHK:
            begin
                if (go)
                begin
                    ram_req.en = 1'b1;
                    ram_addr   = src[AW-1:0];
                    state_next = S_WR;
                end
                else
                begin
                    // Shift finished: place the new code or drop the last entry.
                    if (down)
                    begin
                        ram_req.en = 1'b1;
                        ram_req.we = 1'b1;
                        ram_addr   = AW'(pos_reg);
                        ram_wdata  = code_reg;
                        len_next   = len_reg + LW'(1);
                    end
                    else
                    begin
                        len_next = len_reg - LW'(1);
                    end
                    state_next = S_DONE;
                end
            end
            S_WR:
            begin
                ram_req.en = 1'b1;
                ram_req.we = 1'b1;
                ram_addr   = idx_reg[AW-1:0];
                ram_wdata  = ram_rdata;
                idx_next   = src;
                state_next = S_CHK;
            end
            S_RDW:
            begin
                rdata_next = ram_rdata;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                res.valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign idle  = (state_reg == S_IDLE);
    assign len   = len_reg;
    assign rdata = rdata_reg;

endmodule

[rtl/cursor_insert_delete_buffer.sv]
// Top level of the cursor insert/delete buffer: handshakes, register port, result register.
// Usage:
//   Input channel (in_valid/in_ready) carries kind, position and char_code; one
//   transaction is one insert, delete or read. Output channel (out_valid/out_ready)
//   returns one result per input: status, length_now, almost_full, edited,
//   length_change and read_value.
//   An APB-style port holds baseline_length at byte address 0; write it while idle.
// Operation flow (n = length before the operation, p = position):
//   insert moves the n-p entries at and above p up one place, delete moves the n-1-p
//   entries above p down one place, read fetches one entry, and a refused or unused
//   operation goes straight to the result.
//   Every entry move is a read followed by a write of the single-port text store.
//   One operation is in flight at a time; in_ready is high only while the sequencer
//   is idle, so the next transaction is taken only after the result is handed over.
// Reset: length and edited flag clear; store contents stay undefined until written.
// Stall: a result waits in the output register while out_ready is low; the next
//   operation may be accepted meanwhile and completes once that register frees up.
`timescale 1ns / 1ps

module cursor_insert_delete_buffer #(
    parameter int DEPTH = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          kind,
    input  logic [11:0]         position,
    input  logic signed [31:0]  char_code,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          status,
    output logic [12:0]         length_now,
    output logic                almost_full,
    output logic                edited,
    output logic signed [13:0]  length_change,
    output logic signed [31:0]  read_value,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);
    localparam int DW = ((LW > cidb_pkg::LEN_OUT_W) ? LW : cidb_pkg::LEN_OUT_W) + 2;
    localparam logic signed [DW-1:0] CH_MAX = DW'(cidb_pkg::CHANGE_MAX);
    localparam logic signed [DW-1:0] CH_MIN = DW'(cidb_pkg::CHANGE_MIN);

    cidb_pkg::seq_res_t           res;
    cidb_pkg::ram_req_t           ram_req;
    logic [AW-1:0]                ram_addr;
    logic [cidb_pkg::CODE_W-1:0]  ram_wdata;
    logic [cidb_pkg::CODE_W-1:0]  ram_rdata;
    logic [LW-1:0]                len;
    logic [cidb_pkg::CODE_W-1:0]  rdata;
    logic                         idle;
    logic                         res_ready;
    logic                         cfg_wr;

    logic [cidb_pkg::LEN_OUT_W-1:0] baseline_reg;
    logic                           out_valid_reg;
    logic [1:0]                     status_reg;
    logic [12:0]                    length_reg;
    logic                           almost_full_reg;
    logic                           edited_reg;
    logic signed [13:0]             change_reg;
    logic [31:0]                    read_reg;

    logic signed [DW-1:0]  diff;
    logic signed [DW-1:0]  diff_sat;
    logic [LW:0]           free_cnt;

    assign in_ready  = idle;
    assign res_ready = !out_valid_reg || out_ready;
    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign prdata    = paddr[2] ? 32'd0 : 32'(baseline_reg);

    cidb_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .req   (ram_req),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    cidb_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_valid && in_ready),
        .idle      (idle),
        .kind      (kind),
        .position  (position),
        .char_code (char_code),
        .res       (res),
        .res_ready (res_ready),
        .len       (len),
        .rdata     (rdata),
        .ram_req   (ram_req),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .ram_rdata (ram_rdata)
    );

    always_comb
    begin
        diff = $signed(DW'(len)) - $signed(DW'(baseline_reg));
        if (diff > CH_MAX)
        begin
            diff_sat = CH_MAX;
        end
        else if (diff < CH_MIN)
        begin
            diff_sat = CH_MIN;
        end
        else
        begin
            diff_sat = diff;
        end
        free_cnt = (LW + 1)'(DEPTH) - (LW + 1)'(len);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baseline_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr && !paddr[2])
            begin
                baseline_reg <= pwdata[cidb_pkg::LEN_OUT_W-1:0];
            end
            if (res.valid && res_ready)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Load the result payload when the sequencer hands over a transaction.
    always_ff @(posedge clk)
    begin
        if (res.valid && res_ready)
        begin
            status_reg      <= res.status;
            length_reg      <= 13'(len);
            almost_full_reg <= (free_cnt < (LW + 1)'(cidb_pkg::FREE_LIMIT));
            edited_reg      <= res.edited;
            change_reg      <= 14'(diff_sat);
            read_reg        <= rdata;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign length_now    = length_reg;
    assign almost_full   = almost_full_reg;
    assign edited        = edited_reg;
    assign length_change = change_reg;
    assign read_value    = read_reg;

endmodule

[rtl/cidb_checker.sv]
// Port-level checker of the cursor insert/delete buffer and its bind.
`timescale 1ns / 1ps
`include "cursor_insert_delete_buffer_macros.svh"

module cidb_checker #(
    parameter int DEPTH = 4096
) (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input logic [1:0]          status,
    input logic [12:0]         length_now,
    input logic                edited,
    input logic signed [31:0]  read_value
);

    // A stalled result keeps its payload.
    `CIDB_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(length_now) && $stable(read_value))

    // A full refusal reports a store at full depth.
    `CIDB_ASSERT_IMPLY(a_full_len, clk, rst_n, out_valid && (status == cidb_pkg::ST_FULL), (length_now == 13'(DEPTH)) && edited)

    // An empty refusal reports an empty store and a requested edit.
    `CIDB_ASSERT_IMPLY(a_empty_len, clk, rst_n, out_valid && (status == cidb_pkg::ST_EMPTY), (length_now == 13'd0) && edited)

    // A refused operation never returns store data.
    `CIDB_ASSERT_IMPLY(a_refused_zero, clk, rst_n, out_valid && (status != cidb_pkg::ST_DONE), read_value == 32'sd0)

endmodule

bind cursor_insert_delete_buffer cidb_checker #(
    .DEPTH (DEPTH)
) u_cidb_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .length_now (length_now),
    .edited     (edited),
    .read_value (read_value)
);

[sim/cursor_insert_delete_buffer_test.sv]
// Self-checking testbench of the cursor insert/delete buffer: directed table and random edits.
`timescale 1ns / 1ps

module cursor_insert_delete_buffer_test;

    localparam int DEPTH = 4096;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int IDLE_PERCENT = 33;
    localparam logic [1:0] K_SPARE = 2'd3;
    localparam logic [2:0] BASELINE_ADDR = 3'd0;
    localparam logic [12:0] BASELINE_MAX = 13'h1FFF;

    typedef struct packed {
        cidb_pkg::status_t  status;
        logic [12:0]        len;
        logic               af;
        logic               ed;
        logic signed [13:0] change;
        logic signed [31:0] rv;
    } outcome_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] pos;
        logic [31:0] code;
        logic        typed;
        outcome_t    want;
    } op_row_t;

    localparam outcome_t NO_WANT = '0;
    localparam int DIR_ROWS = 23;

    // Rows with typed set carry their expected outcome; the others go to the predictor.
    localparam op_row_t DIR_TABLE [0:DIR_ROWS-1] = '{
        '{cidb_pkg::K_READ,   12'd0,   32'h0,        1'b1,
            '{cidb_pkg::ST_RANGE, 13'd0, 1'b0, 1'b0, 14'sd0, 32'h0}},
        '{K_SPARE,            12'hFFF, 32'hFFFFFFFF, 1'b1,
            '{cidb_pkg::ST_DONE,  13'd0, 1'b0, 1'b0, 14'sd0, 32'h0}},
        '{cidb_pkg::K_DELETE, 12'd0,   32'h12345678, 1'b1,
            '{cidb_pkg::ST_EMPTY, 13'd0, 1'b0, 1'b1, 14'sd0, 32'h0}},
        '{cidb_pkg::K_INSERT, 12'd1,   32'h11111111, 1'b1,
            '{cidb_pkg::ST_RANGE, 13'd0, 1'b0, 1'b1, 14'sd0, 32'h0}},
        '{cidb_pkg::K_INSERT, 12'hFFF, 32'h22222222, 1'b1,
            '{cidb_pkg::ST_RANGE, 13'd0, 1'b0, 1'b1, 14'sd0, 32'h0}},
        '{cidb_pkg::K_INSERT, 12'd0,   32'h7FFFFFFF, 1'b1,
            '{cidb_pkg::ST_DONE,  13'd1, 1'b0, 1'b1, 14'sd1, 32'h0}},
        '{cidb_pkg::K_INSERT, 12'd1,   32'h80000000, 1'b1,
            '{cidb_pkg::ST_DONE,  13'd2, 1'b0, 1'b1, 14'sd2, 32'h0}},
        '{cidb_pkg::K_INSERT, 12'd0,   32'hFFFFFFFF, 1'b1,
            '{cidb_pkg::ST_DONE,  13'd3, 1'b0, 1'b1, 14'sd3, 32'h0}},
        '{cidb_pkg::K_READ,   12'd0,   32'h33333333, 1'b1,
            '{cidb_pkg::ST_DONE,  13'd3, 1'b0, 1'b1, 14'sd3, 32'hFFFFFFFF}},
        '{cidb_pkg::K_READ,   12'd1,   32'h0,        1'b1,
            '{cidb_pkg::ST_DONE,  13'd3, 1'b0, 1'b1, 14'sd3, 32'h7FFFFFFF}},
        '{cidb_pkg::K_READ,   12'd2,   32'h0,        1'b1,
            '{cidb_pkg::ST_DONE,  13'd3, 1'b0, 1'b1, 14'sd3, 32'h80000000}},
        '{cidb_pkg::K_READ,   12'd3,   32'h0,        1'b1,
            '{cidb_pkg::ST_RANGE, 13'd3, 1'b0, 1'b1, 14'sd3, 32'h0}},
        '{cidb_pkg::K_INSERT, 12'd1,   32'h0,        1'b0, NO_WANT},
        '{cidb_pkg::K_INSERT, 12'd2,   32'h5A5A5A5A, 1'b0, NO_WANT},
        '{cidb_pkg::K_DELETE, 12'd5,   32'hDEADBEEF, 1'b1,
            '{cidb_pkg::ST_RANGE, 13'd5, 1'b0, 1'b1, 14'sd5, 32'h0}},
        '{cidb_pkg::K_DELETE, 12'd1,   32'hDEADBEEF, 1'b0, NO_WANT},
        '{cidb_pkg::K_READ,   12'd1,   32'hFFFFFFFF, 1'b0, NO_WANT},
        '{cidb_pkg::K_DELETE, 12'd3,   32'h0,        1'b0, NO_WANT},
        '{cidb_pkg::K_READ,   12'hFFF, 32'h0,        1'b1,
            '{cidb_pkg::ST_RANGE, 13'd3, 1'b0, 1'b1, 14'sd3, 32'h0}},
        '{cidb_pkg::K_READ,   12'd2,   32'h0,        1'b0, NO_WANT},
        '{cidb_pkg::K_DELETE, 12'd0,   32'h0,        1'b0, NO_WANT},
        '{cidb_pkg::K_READ,   12'd0,   32'h0,        1'b0, NO_WANT},
        '{K_SPARE,            12'd0,   32'h44444444, 1'b1,
            '{cidb_pkg::ST_DONE,  13'd2, 1'b0, 1'b1, 14'sd2, 32'h0}}
    };

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         kind;
    logic [11:0]        position;
    logic signed [31:0] char_code;
    logic               out_valid;
    logic               out_ready;
    logic [1:0]         status;
    logic [12:0]        length_now;
    logic               almost_full;
    logic               edited;
    logic signed [13:0] length_change;
    logic signed [31:0] read_value;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // Shadow copy of the block state.
    logic [31:0] shadow_text [0:DEPTH-1];
    int          shadow_len;
    logic        shadow_edited;
    logic [12:0] shadow_baseline;

    outcome_t pending_outcomes [$];
    bit       sender_idle;
    bit       sink_idle;
    int       mismatch_count;
    int       ops_sent;
    int       outcomes_checked;
    int       status_seen [0:3];
    int       peak_len;
    int       cycle_count;

    cursor_insert_delete_buffer #(
        .DEPTH(DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .kind(kind),
        .position(position),
        .char_code(char_code),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .length_now(length_now),
        .almost_full(almost_full),
        .edited(edited),
        .length_change(length_change),
        .read_value(read_value),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic outcome_t predict_outcome(logic [1:0] op, logic [11:0] pos,
                                                 logic [31:0] code);
        outcome_t o;
        int       i;
        int       delta;
        o = '0;
        o.status = cidb_pkg::ST_DONE;
        case (op)
            cidb_pkg::K_INSERT:
            begin
                shadow_edited = 1'b1;
                if (shadow_len >= DEPTH)
                    o.status = cidb_pkg::ST_FULL;
                else if (int'(pos) > shadow_len)
                    o.status = cidb_pkg::ST_RANGE;
                else
                begin
                    for (i = shadow_len; i > int'(pos); i--)
                        shadow_text[i] = shadow_text[i-1];
                    shadow_text[pos] = code;
                    shadow_len++;
                end
            end
            cidb_pkg::K_DELETE:
            begin
                shadow_edited = 1'b1;
                if (shadow_len == 0)
                    o.status = cidb_pkg::ST_EMPTY;
                else if (int'(pos) >= shadow_len)
                    o.status = cidb_pkg::ST_RANGE;
                else
                begin
                    for (i = int'(pos); i + 1 < shadow_len; i++)
                        shadow_text[i] = shadow_text[i+1];
                    shadow_len--;
                end
            end
            cidb_pkg::K_READ:
            begin
                if (int'(pos) >= shadow_len)
                    o.status = cidb_pkg::ST_RANGE;
                else
                    o.rv = shadow_text[pos];
            end
            default:
            begin
            end
        endcase
        delta = shadow_len - int'(shadow_baseline);
        if (delta > cidb_pkg::CHANGE_MAX)
            delta = cidb_pkg::CHANGE_MAX;
        if (delta < cidb_pkg::CHANGE_MIN)
            delta = cidb_pkg::CHANGE_MIN;
        o.len = 13'(shadow_len);
        o.af = (DEPTH - shadow_len) < cidb_pkg::FREE_LIMIT;
        o.ed = shadow_edited;
        o.change = 14'(delta);
        return o;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH at cycle %0d: %s got %0d, expected %0d", cycle_count, what, got, want);
        mismatch_count++;
    endtask

    function automatic logic [31:0] rand_code();
        case ($urandom_range(0, 11))
            0: return 32'h0;
            1: return 32'hFFFFFFFF;
            2: return 32'h7FFFFFFF;
            3: return 32'h80000000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_op(logic [1:0] op, logic [11:0] pos, logic [31:0] code,
                           logic typed, outcome_t want);
        outcome_t predicted;
        while (sender_idle && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= op;
        position <= pos;
        char_code <= code;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = predict_outcome(op, pos, code);
        pending_outcomes.push_back(typed ? want : predicted);
        ops_sent++;
    endtask

    task automatic send_random_op();
        int          r;
        logic [1:0]  op;
        logic [11:0] pos;
        r = $urandom_range(0, 99);
        // Keep the text short so that shifts stay cheap.
        if (r < 5)
            op = K_SPARE;
        else if (r < 45)
            op = (shadow_len >= 40) ? cidb_pkg::K_DELETE : cidb_pkg::K_INSERT;
        else if (r < 72)
            op = cidb_pkg::K_DELETE;
        else
            op = cidb_pkg::K_READ;
        if ($urandom_range(0, 9) == 0)
            pos = 12'($urandom);
        else
            pos = 12'($urandom_range(0, shadow_len));
        send_op(op, pos, rand_code(), 1'b0, NO_WANT);
    endtask

    task automatic drain_outcomes();
        in_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic reg_access(logic write, logic [2:0] addr, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= write;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (write)
            shadow_baseline = data[12:0];
        else if (prdata[12:0] !== shadow_baseline)
            report_mismatch("baseline_length readback", prdata[12:0], shadow_baseline);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_baseline(logic [12:0] value);
        reg_access(1'b1, BASELINE_ADDR, {19'b0, value});
        reg_access(1'b0, BASELINE_ADDR, 32'h0);
    endtask

    always @(posedge clk)
    begin : result_check
        outcome_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_outcomes.size() == 0)
                    report_mismatch("result with nothing pending, status", status, -1);
                else
                begin
                    want = pending_outcomes.pop_front();
                    if (status !== want.status)
                        report_mismatch("status", status, want.status);
                    if (length_now !== want.len)
                        report_mismatch("length_now", length_now, want.len);
                    if (almost_full !== want.af)
                        report_mismatch("almost_full", almost_full, want.af);
                    if (edited !== want.ed)
                        report_mismatch("edited", edited, want.ed);
                    if (length_change !== want.change)
                        report_mismatch("length_change", length_change, want.change);
                    if (read_value !== want.rv)
                        report_mismatch("read_value", read_value, want.rv);
                    outcomes_checked++;
                    status_seen[want.status]++;
                    if (int'(want.len) > peak_len)
                        peak_len = want.len;
                end
            end
            out_ready <= !sink_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_outcomes.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        int i;
        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = cidb_pkg::K_INSERT;
        position = '0;
        char_code = '0;
        out_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        shadow_len = 0;
        shadow_edited = 1'b0;
        shadow_baseline = '0;
        sender_idle = 1'b1;
        sink_idle = 1'b1;
        mismatch_count = 0;
        ops_sent = 0;
        outcomes_checked = 0;
        peak_len = 0;
        cycle_count = 0;
        for (i = 0; i < 4; i++)
            status_seen[i] = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Baseline comes out of reset as zero.
        reg_access(1'b0, BASELINE_ADDR, 32'h0);
        set_baseline(13'd0);

        for (i = 0; i < DIR_ROWS; i++)
            send_op(DIR_TABLE[i].kind, DIR_TABLE[i].pos, DIR_TABLE[i].code,
                    DIR_TABLE[i].typed, DIR_TABLE[i].want);
        drain_outcomes();

        set_baseline(13'd4096);
        sender_idle = 1'b0;
        sink_idle = 1'b0;
        for (i = 0; i < 40; i++)
        begin
            if (i == 20)
            begin
                sender_idle = 1'b1;
                sink_idle = 1'b1;
                // Hold the sender until every pending result is out.
                drain_outcomes();
            end
            send_random_op();
        end
        drain_outcomes();

        set_baseline(BASELINE_MAX);
        for (i = 0; i < 40; i++)
            send_random_op();
        drain_outcomes();
        repeat (20) @(posedge clk);

        $display("Ran %0d operations over %0d cycles, %0d results checked, peak length %0d",
                 ops_sent, cycle_count, outcomes_checked, peak_len);
        $display("Status mix done/full/empty/range: %0d/%0d/%0d/%0d, %0d mismatches",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 mismatch_count);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
